@@ hw/rtl/boc_pkg.sv @@
// boc_pkg: shared types and codes for the binary opening check block
// request/response payloads, register indexes, controller states and command bundles
// no dependencies
`default_nettype none

package boc_pkg;

    // request function codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_CHECK = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // response kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;
    localparam logic [7:0] DIM_RESET = 8'd1;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] row;
        logic [6:0] col;
        logic       pixel;
    } req_t;

    typedef struct packed {
        logic kind;
        logic possible;
        logic eroded_pixel;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_OUT,
        ST_E_RD,
        ST_E_ACC,
        ST_E_WR,
        ST_O_RD,
        ST_O_ACC,
        ST_O_CTR,
        ST_O_CMP,
        ST_VERDICT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic io_wr;        // store request pixel in source image
        logic io_rd;        // read eroded image at request position
        logic pix_clr;      // restart pixel scan
        logic pix_next;     // advance pixel scan
        logic nb_clr;       // restart window walk
        logic acc_init;     // accumulator value on window restart
        logic nb_next;      // advance window walk
        logic nb_rd;        // read both images at window position
        logic acc_ero;      // fold source neighbour into erosion
        logic acc_open;     // fold eroded neighbour into dilation
        logic ero_wr;       // write eroded pixel
        logic ctr_rd;       // read source at centre pixel
        logic cmp;          // compare opening against source
        logic verdict_init; // set verdict before a check
        logic out_verdict;  // load verdict response
        logic out_read;     // load read response
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic nb_last;
        logic pix_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/boc_ctrl.sv @@
// boc_ctrl: sequencer for load, read and check requests
// drives boc_datapath through cmd_t, watches sts_t; uses boc_pkg
`default_nettype none

module boc_ctrl (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            req_valid,
    output logic           req_ready,
    input  wire [1:0]      req_func,
    input  boc_pkg::sts_t  sts,
    output boc_pkg::cmd_t  cmd
);
    import boc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    unique case (req_func)
                        FUNC_WRITE:
                        begin
                            cmd.io_wr = 1'b1;
                        end
                        FUNC_CHECK:
                        begin
                            cmd.verdict_init = 1'b1;
                            cmd.pix_clr      = 1'b1;
                            cmd.nb_clr       = 1'b1;
                            cmd.acc_init     = 1'b1;
                            state_next = sts.empty ? ST_VERDICT : ST_E_RD;
                        end
                        FUNC_READ:
                        begin
                            cmd.io_rd  = 1'b1;
                            state_next = ST_RD_OUT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_read = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_E_RD:
            begin
                cmd.nb_rd  = 1'b1;
                state_next = ST_E_ACC;
            end
            ST_E_ACC:
            begin
                cmd.acc_ero = 1'b1;
                if (sts.nb_last)
                begin
                    state_next = ST_E_WR;
                end
                else
                begin
                    cmd.nb_next = 1'b1;
                    state_next  = ST_E_RD;
                end
            end
            ST_E_WR:
            begin
                cmd.ero_wr = 1'b1;
                cmd.nb_clr = 1'b1;
                if (sts.pix_last)
                begin
                    cmd.pix_clr = 1'b1;
                    state_next  = ST_O_RD;
                end
                else
                begin
                    cmd.pix_next = 1'b1;
                    cmd.acc_init = 1'b1;
                    state_next   = ST_E_RD;
                end
            end
            ST_O_RD:
            begin
                cmd.nb_rd  = 1'b1;
                state_next = ST_O_ACC;
            end
            ST_O_ACC:
            begin
                cmd.acc_open = 1'b1;
                if (sts.nb_last)
                begin
                    state_next = ST_O_CTR;
                end
                else
                begin
                    cmd.nb_next = 1'b1;
                    state_next  = ST_O_RD;
                end
            end
            ST_O_CTR:
            begin
                cmd.ctr_rd = 1'b1;
                state_next = ST_O_CMP;
            end
            ST_O_CMP:
            begin
                cmd.cmp = 1'b1;
                if (sts.pix_last)
                begin
                    state_next = ST_VERDICT;
                end
                else
                begin
                    cmd.pix_next = 1'b1;
                    cmd.nb_clr   = 1'b1;
                    state_next   = ST_O_RD;
                end
            end
            ST_VERDICT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_verdict = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/boc_datapath.sv @@
// boc_datapath: image stores, scan counters, window accumulator and response register
// obeys cmd_t from boc_ctrl, reports sts_t; uses boc_pkg
`default_nettype none

module boc_datapath #(
    parameter int MAX_ROWS = 128,
    parameter int MAX_COLS = 128
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [boc_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire [boc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  boc_pkg::req_t                    req,
    input  boc_pkg::cmd_t                    cmd,
    output boc_pkg::sts_t                    sts,
    output logic                             rsp_valid,
    input  wire                              rsp_ready,
    output boc_pkg::rsp_t                    rsp
);
    import boc_pkg::*;

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NR_W  = ($clog2(MAX_ROWS + 1) > 8) ? $clog2(MAX_ROWS + 1) : 8;
    localparam int NC_W  = ($clog2(MAX_COLS + 1) > 8) ? $clog2(MAX_COLS + 1) : 8;
    localparam logic [AW:0]   COLS_K  = (AW + 1)'(MAX_COLS);
    localparam logic [NR_W-1:0] MAX_NR = NR_W'(MAX_ROWS);
    localparam logic [NC_W-1:0] MAX_NC = NC_W'(MAX_COLS);

    // configuration
    logic [7:0] rows_reg;
    logic [7:0] cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_RESET;
            cols_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ROWS: rows_reg <= cfg_data;
                REG_COLS: cols_reg <= cfg_data;
                default:  rows_reg <= rows_reg;
            endcase
        end
    end

    logic [NR_W-1:0] nr;
    logic [NC_W-1:0] nc;

    assign nr = (NR_W'(rows_reg) > MAX_NR) ? MAX_NR : NR_W'(rows_reg);
    assign nc = (NC_W'(cols_reg) > MAX_NC) ? MAX_NC : NC_W'(cols_reg);

    // scan state
    logic [RW-1:0] r_reg;
    logic [CW-1:0] c_reg;
    logic [1:0]    dy_reg;
    logic [1:0]    dx_reg;
    logic          acc_reg;
    logic          nb_in_reg;
    logic          verdict_reg;
    logic          rd_in_reg;
    logic          src_q_reg;
    logic          ero_q_reg;

    logic          r_last;
    logic          c_last;

    assign r_last = (NR_W'(r_reg) == nr - NR_W'(1));
    assign c_last = (NC_W'(c_reg) == nc - NC_W'(1));

    assign sts.empty    = (nr == '0) || (nc == '0);
    assign sts.nb_last  = (dy_reg == 2'd2) && (dx_reg == 2'd2);
    assign sts.pix_last = r_last && c_last;
    assign sts.out_free = !rsp_valid || rsp_ready;

    // window position, one above the real coordinate so the top-left border stays positive
    logic [NR_W:0] y_ext;
    logic [NC_W:0] x_ext;
    logic          nb_in;
    logic [RW-1:0] y;
    logic [CW-1:0] x;
    logic [AW-1:0] nb_addr;
    logic [AW-1:0] pix_addr;
    logic [AW-1:0] io_addr;
    logic          io_in;

    assign y_ext   = (NR_W + 1)'(r_reg) + (NR_W + 1)'(dy_reg);
    assign x_ext   = (NC_W + 1)'(c_reg) + (NC_W + 1)'(dx_reg);
    assign nb_in   = (y_ext != '0) && (y_ext <= (NR_W + 1)'(nr))
                  && (x_ext != '0) && (x_ext <= (NC_W + 1)'(nc));
    assign y       = RW'(y_ext - (NR_W + 1)'(1));
    assign x       = CW'(x_ext - (NC_W + 1)'(1));
    assign nb_addr  = AW'((AW + 1)'(y) * COLS_K + (AW + 1)'(x));
    assign pix_addr = AW'((AW + 1)'(r_reg) * COLS_K + (AW + 1)'(c_reg));
    assign io_in    = (32'(req.row) < MAX_ROWS) && (32'(req.col) < MAX_COLS);
    assign io_addr  = AW'((AW + 1)'(RW'(req.row)) * COLS_K + (AW + 1)'(CW'(req.col)));

    // image stores
    logic src_mem [DEPTH];
    logic ero_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.io_wr && io_in)
        begin
            src_mem[io_addr] <= req.pixel;
        end
        if (cmd.nb_rd)
        begin
            src_q_reg <= src_mem[nb_addr];
        end
        else if (cmd.ctr_rd)
        begin
            src_q_reg <= src_mem[pix_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ero_wr)
        begin
            ero_mem[pix_addr] <= acc_reg;
        end
        if (cmd.nb_rd)
        begin
            ero_q_reg <= ero_mem[nb_addr];
        end
        else if (cmd.io_rd)
        begin
            ero_q_reg <= ero_mem[io_addr];
        end
    end

    // counters and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg       <= '0;
            c_reg       <= '0;
            dy_reg      <= '0;
            dx_reg      <= '0;
            acc_reg     <= 1'b0;
            nb_in_reg   <= 1'b0;
            verdict_reg <= 1'b1;
            rd_in_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.pix_clr)
            begin
                r_reg <= '0;
                c_reg <= '0;
            end
            else if (cmd.pix_next)
            begin
                if (c_last)
                begin
                    c_reg <= '0;
                    r_reg <= r_reg + RW'(1);
                end
                else
                begin
                    c_reg <= c_reg + CW'(1);
                end
            end

            if (cmd.nb_clr)
            begin
                dy_reg  <= '0;
                dx_reg  <= '0;
                acc_reg <= cmd.acc_init;
            end
            else
            begin
                if (cmd.nb_next)
                begin
                    if (dx_reg == 2'd2)
                    begin
                        dx_reg <= '0;
                        dy_reg <= dy_reg + 2'd1;
                    end
                    else
                    begin
                        dx_reg <= dx_reg + 2'd1;
                    end
                end
                if (cmd.acc_ero && nb_in_reg && !src_q_reg)
                begin
                    acc_reg <= 1'b0;
                end
                if (cmd.acc_open && nb_in_reg && ero_q_reg)
                begin
                    acc_reg <= 1'b1;
                end
            end

            if (cmd.nb_rd)
            begin
                nb_in_reg <= nb_in;
            end
            if (cmd.io_rd)
            begin
                rd_in_reg <= io_in;
            end

            if (cmd.verdict_init)
            begin
                verdict_reg <= 1'b1;
            end
            else if (cmd.cmp && (acc_reg != src_q_reg))
            begin
                verdict_reg <= 1'b0;
            end
        end
    end

    // response register
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_verdict || cmd.out_read)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_verdict)
        begin
            rsp_reg.kind         <= KIND_VERDICT;
            rsp_reg.possible     <= verdict_reg;
            rsp_reg.eroded_pixel <= 1'b0;
        end
        else if (cmd.out_read)
        begin
            rsp_reg.kind         <= KIND_READ;
            rsp_reg.possible     <= 1'b0;
            rsp_reg.eroded_pixel <= rd_in_reg & ero_q_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ hw/rtl/binary_opening_check.sv @@
// binary_opening_check: top level of the 3x3 binary opening check block
// joins boc_ctrl and boc_datapath; uses boc_pkg
`default_nettype none

// A binary image of up to MAX_ROWS x MAX_COLS pixels is loaded one pixel per
// write transfer (func write, 1 = black) into an on-chip source store; rows and
// cols registers set the image in use, clamped to the store size. A check
// transfer erodes the image into a second store (a pixel stays black only when
// every in-image pixel of its 3x3 window is black), then dilates it again and
// answers whether the opening equals the source; a read transfer returns a
// pixel of the eroded store. After a write a new request can follow at once;
// a read holds the request side until its response is loaded into the output
// register. A check walks every pixel of the image twice with one memory port
// per store, visiting the nine window positions one after another with a read
// step and an accumulate step each, plus a write step per pixel in the erosion
// pass and a centre read and a compare per pixel in the opening pass; requests
// are held off until the verdict is loaded into the output register. A pending
// response sits in the output register, so a new request is taken while the
// previous response waits to be collected.
// Unwritten source pixels inside the image make the verdict meaningless.
module binary_opening_check #(
    parameter int MAX_ROWS = 128,
    parameter int MAX_COLS = 128
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // configuration writes
    input  wire                              cfg_we,
    input  wire [boc_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire [boc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request channel
    input  wire                              req_valid,
    output logic                             req_ready,
    input  boc_pkg::req_t                    req,
    // response channel
    output logic                             rsp_valid,
    input  wire                              rsp_ready,
    output boc_pkg::rsp_t                    rsp
);
    import boc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: idle, read response, erosion pass, opening pass, verdict
    boc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_func  (req.func),
        .sts       (sts),
        .cmd       (cmd)
    );

    // stores, scan counters, window accumulator and output register
    boc_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

@@ hw/rtl/boc_checker.sv @@
// boc_checker: port-level assertions for binary_opening_check, bound to the top level
// uses boc_pkg
`default_nettype none

module boc_checker (
    input wire            clk,
    input wire            rst_n,
    input wire            req_valid,
    input wire            req_ready,
    input boc_pkg::req_t  req,
    input wire            rsp_valid,
    input wire            rsp_ready,
    input boc_pkg::rsp_t  rsp
);
    import boc_pkg::*;

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response dropped or changed while stalled");

    // a check keeps the block busy for at least the following cycle
    a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.func == FUNC_CHECK) |=> !req_ready)
        else $error("request taken during a check");

    // a read keeps the block busy in the following cycle
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.func == FUNC_READ) |=> !req_ready)
        else $error("request taken during a read");

    // unused response fields are zero
    a_rsp_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.kind == KIND_VERDICT) && !rsp.eroded_pixel)
                   || ((rsp.kind == KIND_READ) && !rsp.possible))
        else $error("response carries a stray field");

endmodule

bind binary_opening_check boc_checker u_boc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
